[rtl/deqd_pkg.sv]
// Shared types and constants for the double-ended queue with delete.
// Used by the channel interfaces, the storage cell and the top level.
package deqd_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int OCC_W   = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_DELETE     = 3'd4
   } cmd_type;

   // Operation broadcast to every cell; at most one flag is set per cycle.
   typedef struct packed {
      logic              push_back;
      logic              pop_back;
      logic              push_front;
      logic              pop_front;
      logic              delete_en;
      logic [WORD_W-1:0] word;
   } cell_ctrl_type;

endpackage

[rtl/deqd_ifs.sv]
// Valid/ready channel interfaces for command beats and result beats.
// Depends on deqd_pkg for field widths.
interface deqd_req_if;
   logic                                valid;
   logic                                ready;
   logic [deqd_pkg::CMD_W-1:0]          cmd;
   logic signed [deqd_pkg::WORD_W-1:0]  value_in;

   modport source (output valid, output cmd, output value_in, input ready);
   modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

interface deqd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [deqd_pkg::WORD_W-1:0]  value_out;
   logic [deqd_pkg::OCC_W-1:0]          occupancy;
   logic                                was_empty;
   logic                                push_dropped;
   logic                                match_removed;

   modport source (output valid, output value_out, output occupancy, output was_empty,
                   output push_dropped, output match_removed, input ready);
   modport sink   (input valid, input value_out, input occupancy, input was_empty,
                   input push_dropped, input match_removed, output ready);
endinterface

[rtl/deqd_cell.sv]
// One storage slot of the queue: a word and its valid bit, shifting with its neighbors.
// Depends on deqd_pkg for the control struct and the word width.
module deqd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  deqd_pkg::cell_ctrl_type       ctrl,
   input  logic [deqd_pkg::WORD_W-1:0]   left_data,
   input  logic                          left_valid,
   input  logic [deqd_pkg::WORD_W-1:0]   right_data,
   input  logic                          right_valid,
   input  logic                          match_in,
   output logic                          match_out,
   output logic [deqd_pkg::WORD_W-1:0]   data,
   output logic                          valid,
   output logic [deqd_pkg::WORD_W-1:0]   tail_data
);

   logic [deqd_pkg::WORD_W-1:0] data_ff, data_in;
   logic                        valid_ff, valid_in;
   logic                        is_last;

   assign is_last   = valid_ff & ~right_valid;
   assign match_out = match_in | (valid_ff & (data_ff == ctrl.word));
   assign tail_data = is_last ? data_ff : '0;
   assign data      = data_ff;
   assign valid     = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push_back) begin
         // The first empty slot after the occupied run takes the word.
         if (!valid_ff && left_valid) begin
            data_in  = ctrl.word;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_back) begin
         if (is_last) begin
            valid_in = 1'b0;
         end
      end else if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front || (ctrl.delete_en && match_out)) begin
         // Slots at or after the removed one pull from the right.
         data_in  = right_data;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/double_ended_queue_with_delete_core.sv]
// Top level of the double-ended queue with delete: command decode, cell chain, result register.
// Depends on deqd_pkg, deqd_ifs (channels) and deqd_cell.
//
//   channel    dir   role     payload
//   req_chan   in    sink     cmd, value_in
//   rsp_chan   out   source   value_out, occupancy, was_empty, push_dropped, match_removed
//
// On each command beat all cells compare and shift together, and the
// result lands in the output register at the same edge. The delete search ripples
// through the cell chain, so its length grows with DEPTH.
// A beat is taken when no result is held or the held one is taken: one command per cycle.
// Reset clears the count and the valid bits; stored words are not cleared.
module double_ended_queue_with_delete_core (
   input  logic           clock,
   input  logic           reset,
   deqd_req_if.sink       req_chan,
   deqd_rsp_if.source     rsp_chan
);

   localparam int D = deqd_pkg::DEPTH;
   localparam int W = deqd_pkg::WORD_W;

   logic [deqd_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       rsp_valid_ff;
   logic [W-1:0]               rsp_value_ff, rsp_value_in;
   logic [deqd_pkg::OCC_W-1:0] rsp_occ_ff;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_drop_ff, rsp_drop_in;
   logic                       rsp_match_ff;

   logic                       accept, is_full, is_empty, found;
   deqd_pkg::cell_ctrl_type    ctrl;

   logic [W-1:0]               cell_data [D];
   logic [D-1:0]               cell_valid;
   logic [W-1:0]               cell_tail [D];
   logic [D:0]                 match_chain;
   logic [W-1:0]               tail_word;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign is_full        = (count_ff == deqd_pkg::CNT_W'(D));
   assign is_empty       = (count_ff == '0);

   always_comb begin
      ctrl            = '0;
      ctrl.word       = req_chan.value_in;
      if (accept) begin
         case (deqd_pkg::cmd_type'(req_chan.cmd))
            deqd_pkg::CMD_PUSH_BACK:  ctrl.push_back  = ~is_full;
            deqd_pkg::CMD_POP_BACK:   ctrl.pop_back   = ~is_empty;
            deqd_pkg::CMD_PUSH_FRONT: ctrl.push_front = ~is_full;
            deqd_pkg::CMD_POP_FRONT:  ctrl.pop_front  = ~is_empty;
            deqd_pkg::CMD_DELETE:     ctrl.delete_en  = 1'b1;
            default:                  ctrl.delete_en  = 1'b0;
         endcase
      end
   end

   assign match_chain[0] = 1'b0;
   assign found          = match_chain[D];

   for (genvar i = 0; i < D; i++) begin : g_cell
      logic [W-1:0] left_data, right_data;
      logic         left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_data  = req_chan.value_in;
         assign left_valid = 1'b1;
      end else begin : g_mid_l
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end
      if (i == D - 1) begin : g_tail
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_r
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deqd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .match_in    (match_chain[i]),
         .match_out   (match_chain[i+1]),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .tail_data   (cell_tail[i])
      );
   end

   // At most one cell flags itself as the back entry, so an OR picks its word.
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < D; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_value_in = '0;
      rsp_empty_in = 1'b0;
      rsp_drop_in  = 1'b0;
      case (deqd_pkg::cmd_type'(req_chan.cmd))
         deqd_pkg::CMD_PUSH_BACK, deqd_pkg::CMD_PUSH_FRONT: begin
            rsp_drop_in = is_full;
            if (!is_full) begin
               count_in = count_ff + 1'b1;
            end
         end
         deqd_pkg::CMD_POP_BACK, deqd_pkg::CMD_POP_FRONT: begin
            rsp_empty_in = is_empty;
            if (!is_empty) begin
               count_in     = count_ff - 1'b1;
               rsp_value_in = (req_chan.cmd == deqd_pkg::CMD_POP_BACK) ? tail_word
                                                                      : cell_data[0];
            end
         end
         deqd_pkg::CMD_DELETE: begin
            if (found) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= rsp_value_in;
         rsp_occ_ff   <= deqd_pkg::OCC_W'(count_in);
         rsp_empty_ff <= rsp_empty_in;
         rsp_drop_ff  <= rsp_drop_in;
         rsp_match_ff <= (req_chan.cmd == deqd_pkg::CMD_DELETE) & found;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.value_out     = rsp_value_ff;
   assign rsp_chan.occupancy     = rsp_occ_ff;
   assign rsp_chan.was_empty     = rsp_empty_ff;
   assign rsp_chan.push_dropped  = rsp_drop_ff;
   assign rsp_chan.match_removed = rsp_match_ff;

   // The number of set cell valid bits always equals the count.
   a_valid_run : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == count_ff)
      else $error("cell valid bits disagree with the entry count");

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("front cell valid bit disagrees with the entry count");

   a_occ_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_occ_ff == deqd_pkg::OCC_W'(count_ff))
      else $error("reported occupancy differs from the entry count");

   a_drop_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_drop_ff) |-> is_full)
      else $error("push dropped while the queue was not full");

endmodule

[tb/sv/tb_double_ended_queue_with_delete_core.sv]
// Testbench for double_ended_queue_with_delete_core: drives directed and random command beats, keeps its own
// deque of words that predicts every result beat, and checks each field as results arrive.
// Depends on deqd_pkg, deqd_ifs and the core itself.
module tb_double_ended_queue_with_delete_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [deqd_pkg::WORD_W-1:0] value_out;
      logic [deqd_pkg::OCC_W-1:0]         occupancy;
      logic                               was_empty;
      logic                               push_dropped;
      logic                               match_removed;
   } outcome_type;

   // A drain marker makes the sender hold off until every result has come back.
   typedef struct packed {
      logic                        drain;
      logic [3:0]                  gap;
      logic [deqd_pkg::CMD_W-1:0]  cmd;
      logic [deqd_pkg::WORD_W-1:0] word;
   } command_beat_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_HUNT} mix_type;

   logic clock;
   logic reset;

   deqd_req_if req_bus ();
   deqd_rsp_if rsp_bus ();

   double_ended_queue_with_delete_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   command_beat_type            pending_cmds[$];
   command_beat_type            staged;
   bit                          staged_ok = 1'b0;
   outcome_type                 expected_results[$];
   logic [deqd_pkg::WORD_W-1:0] held_words[$];
   logic [deqd_pkg::WORD_W-1:0] word_pool[8];
   bit                          req_taken = 1'b0;
   bit                          rsp_taken = 1'b0;
   bit                          send_calm = 1'b0;
   bit                          rsp_calm = 1'b0;
   int unsigned                 take_pause = 0;
   int unsigned                 fault_count = 0;

   always #2 clock = ~clock;

   // Predicts the result of one command and updates the held words.
   function automatic outcome_type apply_command(logic [deqd_pkg::CMD_W-1:0] code,
                                                 logic [deqd_pkg::WORD_W-1:0] word);
      outcome_type res;
      int          idx;
      res = '0;
      case (code)
         deqd_pkg::CMD_PUSH_BACK: begin
            if (held_words.size() >= deqd_pkg::DEPTH) res.push_dropped = 1'b1;
            else held_words.push_back(word);
         end
         deqd_pkg::CMD_PUSH_FRONT: begin
            if (held_words.size() >= deqd_pkg::DEPTH) res.push_dropped = 1'b1;
            else held_words.push_front(word);
         end
         deqd_pkg::CMD_POP_BACK: begin
            if (held_words.size() == 0) res.was_empty = 1'b1;
            else res.value_out = held_words.pop_back();
         end
         deqd_pkg::CMD_POP_FRONT: begin
            if (held_words.size() == 0) res.was_empty = 1'b1;
            else res.value_out = held_words.pop_front();
         end
         deqd_pkg::CMD_DELETE: begin
            idx = -1;
            for (int i = 0; i < held_words.size(); i++) begin
               if (idx < 0 && held_words[i] == word) idx = i;
            end
            if (idx >= 0) begin
               held_words.delete(idx);
               res.match_removed = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.occupancy = deqd_pkg::OCC_W'(held_words.size());
      return res;
   endfunction

   task automatic compare_result(outcome_type got);
      outcome_type want;
      if (expected_results.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: result beat with nothing expected: value_out=%0d occupancy=%0d",
                     $realtime, got.value_out, got.occupancy);
      end else begin
         want = expected_results.pop_front();
         if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("%0t: result mismatch", $realtime);
               if (got.value_out !== want.value_out)
                  $display("   value_out     expected %0d got %0d", want.value_out,
                           got.value_out);
               if (got.occupancy !== want.occupancy)
                  $display("   occupancy     expected %0d got %0d", want.occupancy,
                           got.occupancy);
               if (got.was_empty !== want.was_empty)
                  $display("   was_empty     expected %b got %b", want.was_empty,
                           got.was_empty);
               if (got.push_dropped !== want.push_dropped)
                  $display("   push_dropped  expected %b got %b", want.push_dropped,
                           got.push_dropped);
               if (got.match_removed !== want.match_removed)
                  $display("   match_removed expected %b got %b", want.match_removed,
                           got.match_removed);
            end
         end
      end
   endtask

   // Beats are taken at the rising edge; the prediction goes in before the check so that
   // the order of the two within one edge never matters.
   always @(posedge clock) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            expected_results.push_back(apply_command(req_bus.cmd, req_bus.value_in));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            compare_result({rsp_bus.value_out, rsp_bus.occupancy, rsp_bus.was_empty,
                            rsp_bus.push_dropped, rsp_bus.match_removed});
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (!staged_ok && pending_cmds.size() != 0) begin
            staged = pending_cmds.pop_front();
            staged_ok = 1'b1;
         end
         if (!staged_ok) begin
            req_bus.valid <= 1'b0;
         end else if (staged.drain) begin
            req_bus.valid <= 1'b0;
            if (expected_results.size() == 0) staged_ok = 1'b0;
         end else if (staged.gap != 0) begin
            staged.gap = staged.gap - 1'b1;
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.cmd      <= staged.cmd;
            req_bus.value_in <= staged.word;
            req_bus.valid    <= 1'b1;
            staged_ok = 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            take_pause = rsp_calm ? 0 : $urandom_range(0, 10);
         end
         if (take_pause != 0) begin
            take_pause--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic queue_command(logic [deqd_pkg::CMD_W-1:0] code,
                                logic [deqd_pkg::WORD_W-1:0] word);
      command_beat_type beat;
      beat.drain = 1'b0;
      beat.gap   = send_calm ? 4'd0 : 4'($urandom_range(0, 10));
      beat.cmd   = code;
      beat.word  = word;
      pending_cmds.push_back(beat);
   endtask

   task automatic queue_drain();
      command_beat_type beat;
      beat = '0;
      beat.drain = 1'b1;
      pending_cmds.push_back(beat);
   endtask

   // Words mostly come from a small pool so that deletes often find a match.
   function automatic logic [deqd_pkg::WORD_W-1:0] pick_word();
      logic [deqd_pkg::WORD_W-1:0] word;
      case ($urandom_range(0, 9))
         6: word = $urandom();
         7: begin
            case ($urandom_range(0, 3))
               0: word = 32'h8000_0000;
               1: word = 32'h7fff_ffff;
               2: word = '0;
               default: word = '1;
            endcase
         end
         default: word = word_pool[$urandom_range(0, 7)];
      endcase
      return word;
   endfunction

   function automatic logic [deqd_pkg::CMD_W-1:0] pick_push();
      return $urandom_range(0, 1) ? deqd_pkg::CMD_PUSH_FRONT : deqd_pkg::CMD_PUSH_BACK;
   endfunction

   function automatic logic [deqd_pkg::CMD_W-1:0] pick_pop();
      return $urandom_range(0, 1) ? deqd_pkg::CMD_POP_FRONT : deqd_pkg::CMD_POP_BACK;
   endfunction

   function automatic logic [deqd_pkg::CMD_W-1:0] pick_command(mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  return roll < 85 ? pick_push() : deqd_pkg::CMD_W'($urandom_range(0, 4));
         MIX_DRAIN: return roll < 85 ? pick_pop() : pick_push();
         MIX_HUNT: begin
            if (roll < 50) return deqd_pkg::CMD_DELETE;
            return roll < 80 ? pick_push() : pick_pop();
         end
         default:   return deqd_pkg::CMD_W'($urandom_range(0, 4));
      endcase
   endfunction

   initial begin
      int      counted;
      mix_type mix;

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = '0;
      req_bus.value_in = '0;
      rsp_bus.ready    = 1'b0;

      for (int i = 0; i < 8; i++) word_pool[i] = $urandom();
      word_pool[0] = 32'h8000_0000;
      word_pool[1] = 32'h7fff_ffff;

      // Directed: empty pops and delete, field extremes, match and miss, unused codes.
      queue_command(deqd_pkg::CMD_POP_BACK, 32'h1234_5678);
      queue_command(deqd_pkg::CMD_POP_FRONT, '1);
      queue_command(deqd_pkg::CMD_DELETE, '0);
      queue_command(deqd_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
      queue_command(deqd_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
      queue_command(deqd_pkg::CMD_PUSH_BACK, '1);
      queue_command(deqd_pkg::CMD_PUSH_FRONT, '0);
      queue_command(deqd_pkg::CMD_PUSH_BACK, '1);
      queue_command(deqd_pkg::CMD_DELETE, '1);
      queue_command(deqd_pkg::CMD_DELETE, 32'h0000_3039);
      queue_command(deqd_pkg::CMD_W'(deqd_pkg::CMD_DELETE + 1), '1);
      queue_command(deqd_pkg::CMD_W'(deqd_pkg::CMD_DELETE + 2), 32'h5555_aaaa);
      queue_command(deqd_pkg::CMD_W'(deqd_pkg::CMD_DELETE + 3), 32'haaaa_5555);
      queue_command(deqd_pkg::CMD_POP_FRONT, '0);
      queue_command(deqd_pkg::CMD_POP_BACK, '0);
      queue_command(deqd_pkg::CMD_DELETE, 32'h8000_0000);
      queue_command(deqd_pkg::CMD_POP_BACK, '0);
      queue_command(deqd_pkg::CMD_POP_FRONT, '0);
      queue_drain();

      // Random: phases that push the deque to full, empty it, hunt for matches, or mix all commands.
      counted = 0;
      mix = MIX_FILL;
      while (counted < 850) begin
         if (counted % 40 == 0 && counted != 0) begin
            mix = mix_type'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) word_pool[$urandom_range(0, 7)] = $urandom();
         end
         if (counted % 300 == 150) queue_drain();
         if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
         if ($urandom_range(0, 32) == 0) begin
            queue_command(deqd_pkg::CMD_W'($urandom_range(deqd_pkg::CMD_DELETE + 1, 7)),
                          $urandom());
         end else begin
            queue_command(pick_command(mix), pick_word());
            counted++;
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_cmds.size() != 0 || staged_ok || req_bus.valid
             || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
rtl/deqd_pkg.sv
rtl/deqd_ifs.sv
rtl/deqd_cell.sv
rtl/double_ended_queue_with_delete_core.sv
tb/sv/tb_double_ended_queue_with_delete_core.sv
